### rtl/hkr_pkg.sv
// ----------------------------------------------------------------------------
// hkr_pkg: shared types and constants of the keyboard report decoder
// Report and key event payloads, event codes and keycodes.
// ----------------------------------------------------------------------------
package hkr_pkg;

	localparam int SLOTS_MAX = 6;

	// event codes
	localparam logic [3:0] EV_CHAR        = 4'd0;
	localparam logic [3:0] EV_ENTER       = 4'd1;
	localparam logic [3:0] EV_BACKSPACE   = 4'd2;
	localparam logic [3:0] EV_NEW         = 4'd3;
	localparam logic [3:0] EV_MORE        = 4'd4;
	localparam logic [3:0] EV_CTRL_D      = 4'd5;
	localparam logic [3:0] EV_SCROLL_DOWN = 4'd6;
	localparam logic [3:0] EV_SCROLL_UP   = 4'd7;
	localparam logic [3:0] EV_LEFT        = 4'd8;
	localparam logic [3:0] EV_RIGHT       = 4'd9;

	// keycodes
	localparam logic [7:0] KEY_NONE      = 8'h00;
	localparam logic [7:0] KEY_A         = 8'h04;
	localparam logic [7:0] KEY_D         = 8'h07;
	localparam logic [7:0] KEY_M         = 8'h10;
	localparam logic [7:0] KEY_N         = 8'h11;
	localparam logic [7:0] KEY_Z         = 8'h1D;
	localparam logic [7:0] KEY_1         = 8'h1E;
	localparam logic [7:0] KEY_0         = 8'h27;
	localparam logic [7:0] KEY_ENTER     = 8'h28;
	localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
	localparam logic [7:0] KEY_SPACE     = 8'h2C;
	localparam logic [7:0] KEY_MINUS     = 8'h2D;
	localparam logic [7:0] KEY_SLASH     = 8'h38;
	localparam logic [7:0] KEY_CAPS      = 8'h39;
	localparam logic [7:0] KEY_RIGHT     = 8'h4F;
	localparam logic [7:0] KEY_LEFT      = 8'h50;
	localparam logic [7:0] KEY_DOWN      = 8'h51;
	localparam logic [7:0] KEY_UP        = 8'h52;

	localparam logic [7:0] MOD_CTRL  = 8'h11;
	localparam logic [7:0] MOD_SHIFT = 8'h22;

	localparam logic [6:0] CASE_OFFSET = 7'd32;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [3:0] report_length;
		logic [7:0] key_slot0;
		logic [7:0] key_slot1;
		logic [7:0] key_slot2;
		logic [7:0] key_slot3;
		logic [7:0] key_slot4;
		logic [7:0] key_slot5;
	} report_t;

	typedef struct packed {
		logic [3:0] event_kind;
		logic [6:0] char_code;
		logic       last_event;
	} key_event_t;

	// one classified slot, as queued between front and back
	typedef struct packed {
		logic       emit;     // slot gives an event
		logic       caps_key; // slot toggles caps lock
		logic       letter;   // char is a lower-case letter
		logic       flip;     // shift held for a letter
		logic [3:0] kind;
		logic [6:0] ch;
	} slot_t;

endpackage

### rtl/hid_keyboard_report_decoder.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_decoder: boot-keyboard report to key events
// Input side: push a report while full is low; a transaction completes on
// a clock edge with push high and full low.
// Output side: key_event holds the oldest event while empty is low; pop
// high with empty low completes the transaction.
// The front classifies all slots of a report in the accepting cycle and
// writes them into a two-entry report queue. The back takes one event per
// cycle from the head report into a two-entry event queue while that queue
// is not full. With both queues idle, the first event of a report passes
// the report queue and then the event queue before it is on key_event.
// A report that yields nothing is still popped by the back, without an
// event, so that caps lock toggles in order.
// A stalled receiver fills the event queue, then the report queue, and
// full rises; nothing is dropped.
// Reset clears both queues and turns caps lock off.
// ----------------------------------------------------------------------------
module hid_keyboard_report_decoder #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hkr_pkg::report_t    report,
	output logic                full,
	output logic                empty,
	input  logic                pop,
	output hkr_pkg::key_event_t key_event
);

	localparam int DESC_W = KEY_SLOTS * $bits(hkr_pkg::slot_t);
	localparam int EV_W   = $bits(hkr_pkg::key_event_t);

	hkr_pkg::slot_t [KEY_SLOTS-1:0] desc;
	hkr_pkg::slot_t [KEY_SLOTS-1:0] head;
	logic                           rq_push;
	logic                           rq_full;
	logic                           rq_pop;
	logic                           rq_empty;
	logic                           eq_push;
	logic                           eq_full;
	hkr_pkg::key_event_t            ev;

	hkr_front #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_front (
		.push    (push),
		.report  (report),
		.full    (full),
		.rq_full (rq_full),
		.rq_push (rq_push),
		.desc    (desc)
	);

	hkr_fifo #(
		.W(DESC_W)
	) u_report_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (desc),
		.full   (rq_full),
		.pop    (rq_pop),
		.rdata  (head),
		.empty  (rq_empty)
	);

	hkr_back #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rq_empty (rq_empty),
		.slots    (head),
		.rq_pop   (rq_pop),
		.eq_full  (eq_full),
		.eq_push  (eq_push),
		.ev       (ev)
	);

	hkr_fifo #(
		.W(EV_W)
	) u_event_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (eq_push),
		.wdata  (ev),
		.full   (eq_full),
		.pop    (pop),
		.rdata  (key_event),
		.empty  (empty)
	);

endmodule

### rtl/hkr_fifo.sv
// ----------------------------------------------------------------------------
// hkr_fifo: two-entry queue
// Registered storage with full and empty flags; push and pop may complete in the same cycle.
// ----------------------------------------------------------------------------
module hkr_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

### rtl/hkr_front.sv
// ----------------------------------------------------------------------------
// hkr_front: report intake and slot classification
// Accepts a report and classifies each slot in range into an event template.
// ----------------------------------------------------------------------------
module hkr_front #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                              push,
	input  hkr_pkg::report_t                  report,
	output logic                              full,
	input  logic                              rq_full,
	output logic                              rq_push,
	output hkr_pkg::slot_t [KEY_SLOTS-1:0]    desc
);

	logic [7:0] codes [hkr_pkg::SLOTS_MAX];
	logic       ctrl;
	logic       shift;

	function automatic logic [6:0] digit_char(input logic [7:0] code, input logic sh);
		logic [6:0] c;
		c = 7'h00;
		case (code)
			8'h1E: c = sh ? 7'h21 : 7'h31;
			8'h1F: c = sh ? 7'h40 : 7'h32;
			8'h20: c = sh ? 7'h23 : 7'h33;
			8'h21: c = sh ? 7'h24 : 7'h34;
			8'h22: c = sh ? 7'h25 : 7'h35;
			8'h23: c = sh ? 7'h5E : 7'h36;
			8'h24: c = sh ? 7'h26 : 7'h37;
			8'h25: c = sh ? 7'h2A : 7'h38;
			8'h26: c = sh ? 7'h28 : 7'h39;
			8'h27: c = sh ? 7'h29 : 7'h30;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] punct_char(input logic [7:0] code, input logic sh);
		logic [6:0] c;
		c = 7'h00;
		case (code)
			8'h2D: c = sh ? 7'h5F : 7'h2D;
			8'h2E: c = sh ? 7'h2B : 7'h3D;
			8'h2F: c = sh ? 7'h7B : 7'h5B;
			8'h30: c = sh ? 7'h7D : 7'h5D;
			8'h31: c = sh ? 7'h7C : 7'h5C;
			8'h33: c = sh ? 7'h3A : 7'h3B;
			8'h34: c = sh ? 7'h22 : 7'h27;
			8'h35: c = sh ? 7'h7E : 7'h60;
			8'h36: c = sh ? 7'h3C : 7'h2C;
			8'h37: c = sh ? 7'h3E : 7'h2E;
			8'h38: c = sh ? 7'h3F : 7'h2F;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic hkr_pkg::slot_t classify(input logic [7:0] code, input logic ct,
			input logic sh);
		hkr_pkg::slot_t s;
		s      = '0;
		s.emit = 1'b1;
		s.kind = hkr_pkg::EV_CHAR;
		if (code == hkr_pkg::KEY_NONE) begin
			s.emit = 1'b0;
		end else if (code == hkr_pkg::KEY_CAPS) begin
			s.emit     = 1'b0;
			s.caps_key = 1'b1;
		end else if (ct && code == hkr_pkg::KEY_N) begin
			s.kind = hkr_pkg::EV_NEW;
		end else if (ct && code == hkr_pkg::KEY_M) begin
			s.kind = hkr_pkg::EV_MORE;
		end else if (ct && code == hkr_pkg::KEY_D) begin
			s.kind = hkr_pkg::EV_CTRL_D;
		end else if (code == hkr_pkg::KEY_UP) begin
			s.kind = hkr_pkg::EV_SCROLL_DOWN;
		end else if (code == hkr_pkg::KEY_DOWN) begin
			s.kind = hkr_pkg::EV_SCROLL_UP;
		end else if (code == hkr_pkg::KEY_LEFT) begin
			s.kind = hkr_pkg::EV_LEFT;
		end else if (code == hkr_pkg::KEY_RIGHT) begin
			s.kind = hkr_pkg::EV_RIGHT;
		end else if (code == hkr_pkg::KEY_ENTER) begin
			s.kind = hkr_pkg::EV_ENTER;
		end else if (code == hkr_pkg::KEY_BACKSPACE) begin
			s.kind = hkr_pkg::EV_BACKSPACE;
		end else if (code inside {[hkr_pkg::KEY_A:hkr_pkg::KEY_Z]}) begin
			// case is settled in the back, once caps lock is known
			s.letter = 1'b1;
			s.flip   = sh;
			s.ch     = 7'h61 + 7'(code - hkr_pkg::KEY_A);
		end else if (code inside {[hkr_pkg::KEY_1:hkr_pkg::KEY_0]}) begin
			s.ch = digit_char(code, sh);
		end else if (code == hkr_pkg::KEY_SPACE) begin
			s.ch = 7'h20;
		end else if (code inside {[hkr_pkg::KEY_MINUS:hkr_pkg::KEY_SLASH]}) begin
			s.ch = punct_char(code, sh);
			if (s.ch == 7'h00) s.emit = 1'b0;
		end else begin
			s.emit = 1'b0;
		end
		return s;
	endfunction

	assign codes[0] = report.key_slot0;
	assign codes[1] = report.key_slot1;
	assign codes[2] = report.key_slot2;
	assign codes[3] = report.key_slot3;
	assign codes[4] = report.key_slot4;
	assign codes[5] = report.key_slot5;

	assign ctrl    = |(report.modifier_bits & hkr_pkg::MOD_CTRL);
	assign shift   = |(report.modifier_bits & hkr_pkg::MOD_SHIFT);
	assign full    = rq_full;
	assign rq_push = push && !rq_full;

	always_comb begin
		for (int k = 0; k < KEY_SLOTS; k++) begin
			// slot k sits in report byte k+2; a short report leaves it out
			if (4'(k + 2) < report.report_length) begin
				desc[k] = classify(codes[k], ctrl, shift);
			end else begin
				desc[k] = '0;
			end
		end
	end

endmodule

### rtl/hkr_back.sv
// ----------------------------------------------------------------------------
// hkr_back: event issue
// Walks the queued slots one event a cycle while the event queue is not full, applies caps lock, marks the last.
// ----------------------------------------------------------------------------
module hkr_back #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rq_empty,
	input  hkr_pkg::slot_t [KEY_SLOTS-1:0] slots,
	output logic                           rq_pop,
	input  logic                           eq_full,
	output logic                           eq_push,
	output hkr_pkg::key_event_t            ev
);

	logic [KEY_SLOTS-1:0] done_q;
	logic                 caps_q;
	logic [KEY_SLOTS-1:0] emit_bits;
	logic [KEY_SLOTS-1:0] caps_bits;
	logic [KEY_SLOTS-1:0] rem;
	logic [KEY_SLOTS-1:0] sel;
	logic                 has;
	logic                 last;
	logic                 caps_now;
	hkr_pkg::slot_t       cur;

	always_comb begin
		for (int k = 0; k < KEY_SLOTS; k++) begin
			emit_bits[k] = slots[k].emit;
			caps_bits[k] = slots[k].caps_key;
		end
	end

	assign rem  = emit_bits & ~done_q;
	assign has  = |rem;
	assign sel  = rem & (~rem + KEY_SLOTS'(1));
	assign last = ((rem & ~sel) == '0);
	// caps lock as left by the caps keys in slots before the selected one
	assign caps_now = caps_q ^ (^(caps_bits & (sel - KEY_SLOTS'(1))));

	always_comb begin
		cur = '0;
		for (int k = 0; k < KEY_SLOTS; k++) begin
			if (sel[k]) cur = cur | slots[k];
		end
	end

	always_comb begin
		ev.event_kind = cur.kind;
		ev.last_event = last;
		if (cur.letter && (cur.flip ^ caps_now)) ev.char_code = cur.ch - hkr_pkg::CASE_OFFSET;
		else                                     ev.char_code = cur.ch;
	end

	assign eq_push = !rq_empty && has && !eq_full;
	// a report with nothing to give leaves without waiting for the event queue
	assign rq_pop  = !rq_empty && (!has || (!eq_full && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			caps_q <= 1'b0;
		end else begin
			if (rq_pop) begin
				done_q <= '0;
				caps_q <= caps_q ^ (^caps_bits);
			end else if (eq_push) begin
				done_q <= done_q | sel;
			end
		end
	end

endmodule

### test/hid_keyboard_report_decoder_checker.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_decoder_checker: key event scoreboard
// Watches both queue interfaces of the report decoder. Every accepted report
// is decoded here into the key events it must give, with a local caps lock
// flag. Every accepted event is compared field by field with the oldest one
// still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hid_keyboard_report_decoder_checker
	import hkr_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  report_t    report,
	input  logic       full,
	input  logic       empty,
	input  logic       pop,
	input  key_event_t key_event,
	output int         errors,
	output int         pending,
	output int         reports_seen,
	output int         events_seen
);

	localparam logic [7:0]  KEY_NON_US_HASH = 8'h32;
	localparam int          MAX_LENGTH      = 8;
	localparam int          FIRST_SLOT_BYTE = 2;
	localparam logic [79:0] DIGIT_SHIFTED   = "!@#$%^&*()";
	// the backtick goes in as a byte of its own
	localparam logic [95:0] PUNCT_PLAIN     = {"-=[]\\ ;'", 8'h60, ",./"};
	localparam logic [95:0] PUNCT_SHIFTED   = "_+{}| :\"~<>?";

	logic       caps_on;
	key_event_t owed_events[$];
	key_event_t want;

	// ASCII for a keycode, zero where the code has no character
	function automatic logic [6:0] key_char(logic [7:0] code, logic shift, logic caps);
		logic [6:0] ch;
		int         i;
		ch = '0;
		if (code >= KEY_A && code <= KEY_Z) begin
			ch = 7'("a") + 7'(code - KEY_A);
			if (shift != caps)
				ch = ch - CASE_OFFSET;
		end else if (code >= KEY_1 && code <= KEY_0) begin
			i = int'(code - KEY_1);
			if (shift)
				ch = DIGIT_SHIFTED[8 * (9 - i) +: 7];
			else if (code == KEY_0)
				ch = 7'("0");
			else
				ch = 7'("1") + 7'(i);
		end else if (code == KEY_SPACE) begin
			ch = 7'(" ");
		end else if (code >= KEY_MINUS && code <= KEY_SLASH && code != KEY_NON_US_HASH) begin
			i = int'(code - KEY_MINUS);
			ch = shift ? PUNCT_SHIFTED[8 * (11 - i) +: 7] : PUNCT_PLAIN[8 * (11 - i) +: 7];
		end
		return ch;
	endfunction

	// queue the events one report owes and track caps lock through it
	function automatic void decode_report(report_t r);
		logic [7:0] slots [SLOTS_MAX];
		logic       ctrl;
		logic       shift;
		logic       emit;
		logic       have_held;
		int         len;
		key_event_t ev;
		key_event_t held;
		slots     = '{r.key_slot0, r.key_slot1, r.key_slot2,
		              r.key_slot3, r.key_slot4, r.key_slot5};
		ctrl      = |(r.modifier_bits & MOD_CTRL);
		shift     = |(r.modifier_bits & MOD_SHIFT);
		len       = int'(r.report_length);
		have_held = 1'b0;
		held      = '0;
		if (len > MAX_LENGTH)
			len = MAX_LENGTH;
		for (int k = 0; k < len - FIRST_SLOT_BYTE && k < KEY_SLOTS; k++) begin
			emit = 1'b1;
			ev   = '0;
			if (slots[k] == KEY_NONE)
				continue;
			if (slots[k] == KEY_CAPS) begin
				caps_on = !caps_on;
				emit    = 1'b0;
			end else if (ctrl && slots[k] == KEY_N) begin
				ev.event_kind = EV_NEW;
			end else if (ctrl && slots[k] == KEY_M) begin
				ev.event_kind = EV_MORE;
			end else if (ctrl && slots[k] == KEY_D) begin
				ev.event_kind = EV_CTRL_D;
			end else if (slots[k] == KEY_UP) begin
				ev.event_kind = EV_SCROLL_DOWN;
			end else if (slots[k] == KEY_DOWN) begin
				ev.event_kind = EV_SCROLL_UP;
			end else if (slots[k] == KEY_LEFT) begin
				ev.event_kind = EV_LEFT;
			end else if (slots[k] == KEY_RIGHT) begin
				ev.event_kind = EV_RIGHT;
			end else if (slots[k] == KEY_ENTER) begin
				ev.event_kind = EV_ENTER;
			end else if (slots[k] == KEY_BACKSPACE) begin
				ev.event_kind = EV_BACKSPACE;
			end else begin
				ev.event_kind = EV_CHAR;
				ev.char_code  = key_char(slots[k], shift, caps_on);
				emit          = ev.char_code != '0;
			end
			if (emit) begin
				// hold one event back so the final one can be marked
				if (have_held)
					owed_events.push_back(held);
				held      = ev;
				have_held = 1'b1;
			end
		end
		if (have_held) begin
			held.last_event = 1'b1;
			owed_events.push_back(held);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			caps_on      = 1'b0;
			errors       = 0;
			reports_seen = 0;
			events_seen  = 0;
			owed_events.delete();
		end else begin
			// the event side first: nothing pushed at this edge can be out yet
			if (pop && !empty) begin
				events_seen++;
				if (owed_events.size() == 0) begin
					$error("unexpected event: kind %0d, char %0h, last %0d",
						key_event.event_kind, key_event.char_code, key_event.last_event);
					errors++;
				end else begin
					want = owed_events.pop_front();
					if (key_event.event_kind != want.event_kind) begin
						$error("event_kind: expected %0d, got %0d",
							want.event_kind, key_event.event_kind);
						errors++;
					end
					if (key_event.char_code != want.char_code) begin
						$error("char_code: expected %0h, got %0h",
							want.char_code, key_event.char_code);
						errors++;
					end
					if (key_event.last_event != want.last_event) begin
						$error("last_event: expected %0d, got %0d",
							want.last_event, key_event.last_event);
						errors++;
					end
				end
			end
			if (push && !full) begin
				reports_seen++;
				decode_report(report);
			end
		end
		pending = owed_events.size();
	end

endmodule

### test/tb_hid_keyboard_report_decoder.sv
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_decoder: testbench of the keyboard report decoder
// Sends a directed set of reports covering lengths, modifiers, caps lock,
// every key group and unmapped codes, then random reports, while both sides
// stall at random. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hid_keyboard_report_decoder;
	import hkr_pkg::*;

	localparam int KEY_SLOTS      = 6;
	localparam int RANDOM_REPORTS = 236;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 16;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic       empty;
	logic       pop;
	report_t    report;
	key_event_t key_event;
	logic       idling_on;
	int         errors;
	int         pending;
	int         reports_seen;
	int         events_seen;
	int         cycles = 0;

	always #4 clk = ~clk;

	hid_keyboard_report_decoder #(
		.KEY_SLOTS(KEY_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.report(report),
		.full(full),
		.empty(empty),
		.pop(pop),
		.key_event(key_event)
	);

	hid_keyboard_report_decoder_checker #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.report(report),
		.full(full),
		.empty(empty),
		.pop(pop),
		.key_event(key_event),
		.errors(errors),
		.pending(pending),
		.reports_seen(reports_seen),
		.events_seen(events_seen)
	);

	// receiver: stall now and then
	always @(negedge clk)
		pop <= arst_n && !(idling_on && $urandom_range(99) < 9);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_hid_keyboard_report_decoder: errors");
			$finish;
		end
	end

	function automatic report_t make_report(logic [7:0] modifiers, logic [3:0] len,
		logic [7:0] k0, logic [7:0] k1, logic [7:0] k2,
		logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
		report_t r;
		r.modifier_bits = modifiers;
		r.report_length = len;
		r.key_slot0     = k0;
		r.key_slot1     = k1;
		r.key_slot2     = k2;
		r.key_slot3     = k3;
		r.key_slot4     = k4;
		r.key_slot5     = k5;
		return r;
	endfunction

	// mostly meaningful keys, some empty slots and some raw bytes
	function automatic logic [7:0] random_key();
		int pick;
		pick = $urandom_range(99);
		if (pick < 42)
			return KEY_A + 8'($urandom_range(25));
		if (pick < 52)
			return KEY_1 + 8'($urandom_range(9));
		if (pick < 60)
			return KEY_MINUS + 8'($urandom_range(11));
		if (pick < 64)
			return KEY_CAPS;
		if (pick < 72) begin
			case ($urandom_range(6))
				0:       return KEY_ENTER;
				1:       return KEY_BACKSPACE;
				2:       return KEY_SPACE;
				3:       return KEY_UP;
				4:       return KEY_DOWN;
				5:       return KEY_LEFT;
				default: return KEY_RIGHT;
			endcase
		end
		if (pick < 82)
			return KEY_NONE;
		return 8'($urandom_range(255));
	endfunction

	function automatic report_t random_report();
		logic [7:0] modifiers;
		logic [3:0] len;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 40)
			modifiers = '0;
		else if (pick < 55)
			modifiers = MOD_CTRL & 8'($urandom_range(255));
		else if (pick < 70)
			modifiers = MOD_SHIFT & 8'($urandom_range(255));
		else
			modifiers = 8'($urandom_range(255));
		len = ($urandom_range(99) < 70) ? 4'd8 : 4'($urandom_range(15));
		return make_report(modifiers, len, random_key(), random_key(), random_key(),
			random_key(), random_key(), random_key());
	endfunction

	// hold the report until the transaction completes
	task automatic send_report(input report_t r);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < 9) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push   <= 1'b1;
		report <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	initial begin
		push      = 1'b0;
		report    = '0;
		arst_n    = 1'b0;
		idling_on = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lengths too short to reach any slot
		send_report(make_report(8'h00, 4'd0, KEY_A, KEY_Z, KEY_1, KEY_0, KEY_ENTER, KEY_UP));
		send_report(make_report(8'h00, 4'd1, KEY_A, KEY_Z, KEY_1, KEY_0, KEY_ENTER, KEY_UP));
		send_report(make_report(8'h00, 4'd2, KEY_A, KEY_Z, KEY_CAPS, KEY_0, KEY_ENTER, KEY_UP));
		// letters plain, with left shift, with right shift on one slot only
		send_report(make_report(8'h00, 4'd8, KEY_A, KEY_Z, KEY_A + 8'd1, KEY_M, KEY_N, KEY_D));
		send_report(make_report(8'h02, 4'd8, KEY_A, KEY_Z, KEY_A + 8'd1, KEY_M, KEY_N, KEY_D));
		send_report(make_report(8'h20, 4'd3, KEY_Z, KEY_A, KEY_A, KEY_A, KEY_A, KEY_A));
		// caps lock toggled mid-report, alone and against shift
		send_report(make_report(8'h00, 4'd8, KEY_A, KEY_CAPS, KEY_A, KEY_NONE, KEY_Z, KEY_CAPS));
		send_report(make_report(MOD_SHIFT, 4'd8, KEY_CAPS, KEY_A, KEY_CAPS, KEY_A, KEY_CAPS,
			KEY_Z));
		send_report(make_report(8'h00, 4'd8, KEY_A, KEY_Z, KEY_CAPS, KEY_A, KEY_NONE, KEY_NONE));
		// digits and punctuation, plain and shifted
		send_report(make_report(8'h00, 4'd8, KEY_1, KEY_1 + 8'd1, KEY_1 + 8'd2, KEY_1 + 8'd3,
			KEY_1 + 8'd4, KEY_1 + 8'd5));
		send_report(make_report(8'h00, 4'd8, KEY_1 + 8'd6, KEY_1 + 8'd7, KEY_1 + 8'd8, KEY_0,
			KEY_SPACE, KEY_NONE));
		send_report(make_report(8'h02, 4'd8, KEY_1, KEY_1 + 8'd1, KEY_1 + 8'd2, KEY_1 + 8'd3,
			KEY_1 + 8'd4, KEY_1 + 8'd5));
		send_report(make_report(8'h20, 4'd8, KEY_1 + 8'd6, KEY_1 + 8'd7, KEY_1 + 8'd8, KEY_0,
			KEY_SPACE, KEY_NONE));
		send_report(make_report(8'h00, 4'd8, KEY_MINUS, KEY_MINUS + 8'd1, KEY_MINUS + 8'd2,
			KEY_MINUS + 8'd3, KEY_MINUS + 8'd4, KEY_MINUS + 8'd5));
		send_report(make_report(8'h00, 4'd8, KEY_MINUS + 8'd6, KEY_MINUS + 8'd7,
			KEY_MINUS + 8'd8, KEY_MINUS + 8'd9, KEY_MINUS + 8'd10, KEY_SLASH));
		send_report(make_report(MOD_SHIFT, 4'd8, KEY_MINUS, KEY_MINUS + 8'd1, KEY_MINUS + 8'd2,
			KEY_MINUS + 8'd3, KEY_MINUS + 8'd4, KEY_MINUS + 8'd5));
		send_report(make_report(8'h02, 4'd8, KEY_MINUS + 8'd6, KEY_MINUS + 8'd7,
			KEY_MINUS + 8'd8, KEY_MINUS + 8'd9, KEY_MINUS + 8'd10, KEY_SLASH));
		// ctrl commands from either ctrl key, and ctrl with other keys
		send_report(make_report(8'h01, 4'd8, KEY_N, KEY_M, KEY_D, KEY_A, KEY_1, KEY_UP));
		send_report(make_report(8'h10, 4'd8, KEY_D, KEY_N, KEY_M, KEY_Z, KEY_NONE, KEY_NONE));
		send_report(make_report(8'h00, 4'd8, KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_ENTER,
			KEY_BACKSPACE));
		// codes with no mapping, then every modifier with an overlong length
		send_report(make_report(8'h00, 4'd8, 8'hFF, 8'h01, 8'h03, 8'h3A, 8'h80, KEY_NONE));
		send_report(make_report(8'hFF, 4'd15, KEY_N, KEY_A, KEY_CAPS, KEY_A, KEY_1, KEY_SLASH));
		// partial length and gaps between keys
		send_report(make_report(8'h00, 4'd5, KEY_A, KEY_A + 8'd1, KEY_A + 8'd2, KEY_A + 8'd3,
			KEY_A + 8'd4, KEY_ENTER));
		send_report(make_report(8'h00, 4'd9, KEY_NONE, KEY_A, KEY_NONE, KEY_ENTER, KEY_NONE,
			KEY_Z));

		for (int i = 0; i < RANDOM_REPORTS; i++) begin
			// a stretch with no stalls on either side
			idling_on = !(i >= 100 && i < 160);
			send_report(random_report());
		end
		idling_on = 1'b1;

		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d reports accepted, %0d key events checked", reports_seen, events_seen);
		$display("short and overlong lengths, caps lock, shift, ctrl and unmapped keys hit");
		if (errors == 0 && pending == 0)
			$display("tb_hid_keyboard_report_decoder: clean");
		else
			$display("tb_hid_keyboard_report_decoder: errors");
		$finish;
	end

endmodule
